FILE: src/udivr_pkg.sv
// Shared constants and types for the pipelined unsigned divider.
// No dependencies; imported by udivr_stage, unsigned_divide_with_remainder and tb_top.
`timescale 1ns / 1ps

package udivr_pkg;

    // Width of every operand and result port
    localparam int FIELD_WIDTH = 32;

    // Widest working width the pipeline supports
    localparam int MAX_WIDTH = 64;

    // Default working width of the pipeline
    localparam int DEFAULT_OPERAND_WIDTH = 32;

    // Control that travels with each request down the pipeline
    typedef struct packed {
        logic valid;
        logic div_zero;
    } ctrl_t;

endpackage

FILE: src/udivr_stage.sv
// One registered restoring-division step: resolves a single quotient bit.
// Depends on udivr_pkg (ctrl_t).
`timescale 1ns / 1ps

module udivr_stage #(
    parameter int OPERAND_WIDTH = 32,
    parameter int POS           = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  udivr_pkg::ctrl_t         ctrl_in,
    input  logic [OPERAND_WIDTH-1:0] rem_in,
    input  logic [OPERAND_WIDTH-1:0] dsr_in,
    input  logic [OPERAND_WIDTH-1:0] quo_in,
    output udivr_pkg::ctrl_t         ctrl_out,
    output logic [OPERAND_WIDTH-1:0] rem_out,
    output logic [OPERAND_WIDTH-1:0] dsr_out,
    output logic [OPERAND_WIDTH-1:0] quo_out
);

    import udivr_pkg::*;

    localparam logic [OPERAND_WIDTH-1:0] QBIT =
        {{(OPERAND_WIDTH-1){1'b0}}, 1'b1} << POS;

    ctrl_t                    ctrl_reg;
    logic [OPERAND_WIDTH-1:0] rem_reg;
    logic [OPERAND_WIDTH-1:0] dsr_reg;
    logic [OPERAND_WIDTH-1:0] quo_reg;
    logic [OPERAND_WIDTH-1:0] rem_next;
    logic [OPERAND_WIDTH-1:0] quo_next;
    logic                     fits;

    // Trial subtract: comparing the shifted-down remainder also rejects any
    // shift that would push divisor bits off the top of the word
    assign fits = (rem_in >> POS) >= dsr_in;

    always_comb
    begin
        rem_next = rem_in;
        quo_next = quo_in;
        if (fits)
        begin
            rem_next = rem_in - (dsr_in << POS);
            quo_next = quo_in | QBIT;
        end
    end

    // Advance the control bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_in;
        quo_reg <= quo_next;
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign dsr_out  = dsr_reg;
    assign quo_out  = quo_reg;

endmodule

FILE: src/unsigned_divide_with_remainder.sv
// Unsigned divider with remainder, fully pipelined, one request per cycle.
// Each request is accepted at a clock edge with start high (busy is always low) and passes
// through one registered pipeline stage per quotient bit, each stage holding one
// compare-and-subtract; its result then appears on done, quotient, remainder and
// divide_by_zero for one cycle only; the receiver cannot stall it and must take it then.
// A zero divisor yields an all-ones quotient, the dividend as remainder and divide_by_zero
// high. Depends on udivr_pkg and udivr_stage.
`timescale 1ns / 1ps

module unsigned_divide_with_remainder #(
    parameter int OPERAND_WIDTH = udivr_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [udivr_pkg::FIELD_WIDTH-1:0] dividend,
    input  logic [udivr_pkg::FIELD_WIDTH-1:0] divisor,
    output logic                              done,
    output logic [udivr_pkg::FIELD_WIDTH-1:0] quotient,
    output logic [udivr_pkg::FIELD_WIDTH-1:0] remainder,
    output logic                              divide_by_zero
);

    import udivr_pkg::*;

    localparam int W = OPERAND_WIDTH;

    // Expected quotient on a zero divisor: working-width ones, cut to the port
    localparam logic [MAX_WIDTH-1:0]   ONES_WIDE = {MAX_WIDTH{1'b1}} >> (MAX_WIDTH - W);
    localparam logic [FIELD_WIDTH-1:0] QUO_ONES  = ONES_WIDE[FIELD_WIDTH-1:0];

    ctrl_t          ctrl_s [0:W];
    logic [W-1:0]   rem_s  [0:W];
    logic [W-1:0]   dsr_s  [0:W];
    logic [W-1:0]   quo_s  [0:W];

    logic [MAX_WIDTH-1:0] dividend_wide;
    logic [MAX_WIDTH-1:0] divisor_wide;
    logic [MAX_WIDTH-1:0] quo_wide;
    logic [MAX_WIDTH-1:0] rem_wide;

    // The pipeline never holds a request off
    assign busy = 1'b0;

    // Bring operands to the working width
    assign dividend_wide = {{(MAX_WIDTH-FIELD_WIDTH){1'b0}}, dividend};
    assign divisor_wide  = {{(MAX_WIDTH-FIELD_WIDTH){1'b0}}, divisor};

    assign ctrl_s[0].valid    = start && !busy;
    assign ctrl_s[0].div_zero = (divisor_wide[W-1:0] == '0);
    assign rem_s[0]           = dividend_wide[W-1:0];
    assign dsr_s[0]           = divisor_wide[W-1:0];
    assign quo_s[0]           = '0;

    // One stage per quotient bit, top bit first
    for (genvar k = 0; k < W; k++)
    begin : g_stage
        udivr_stage #(
            .OPERAND_WIDTH (W),
            .POS           (W - 1 - k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_s[k]),
            .rem_in   (rem_s[k]),
            .dsr_in   (dsr_s[k]),
            .quo_in   (quo_s[k]),
            .ctrl_out (ctrl_s[k+1]),
            .rem_out  (rem_s[k+1]),
            .dsr_out  (dsr_s[k+1]),
            .quo_out  (quo_s[k+1])
        );
    end

    // Drop the result onto the port width
    assign quo_wide = MAX_WIDTH'(quo_s[W]);
    assign rem_wide = MAX_WIDTH'(rem_s[W]);

    assign done           = ctrl_s[W].valid;
    assign quotient       = quo_wide[FIELD_WIDTH-1:0];
    assign remainder      = rem_wide[FIELD_WIDTH-1:0];
    assign divide_by_zero = ctrl_s[W].div_zero;

    // Every result comes from a request taken as it entered the first pipeline stage
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, W))
        else $error("result strobe without a matching request");

    // A zero divisor leaves every quotient bit set
    a_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (quotient == QUO_ONES))
        else $error("zero divisor did not give an all-ones quotient");

    // A proper division leaves a remainder below the divisor
    a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_s[W].valid && !ctrl_s[W].div_zero) |-> (rem_s[W] < dsr_s[W]))
        else $error("remainder not below divisor");

    // The divisor flag agrees with the divisor carried to the end
    a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_s[W].valid |-> (ctrl_s[W].div_zero == (dsr_s[W] == '0)))
        else $error("divide-by-zero flag out of step with divisor");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the pipelined unsigned divider with remainder.
// Depends on udivr_pkg and unsigned_divide_with_remainder, which in turn needs udivr_stage.
`timescale 1ns / 1ps

module tb_top;

    import udivr_pkg::*;

    // Pipeline depth of the default build, one stage per quotient bit
    localparam int DIV_LATENCY = DEFAULT_OPERAND_WIDTH;
    // Cycles with no request taken and no result seen before the run is abandoned
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 425;
    localparam int NUM_VECTORS = 23;
    localparam int MAX_REPORTS = 40;

    typedef logic [FIELD_WIDTH-1:0] word_t;

    typedef struct packed {
        word_t quo;
        word_t rem;
        logic  by_zero;
    } division_result_t;

    typedef struct packed {
        word_t            num;
        word_t            den;
        logic             known;
        division_result_t want;
    } division_vector_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  start;
    logic  busy;
    word_t dividend;
    word_t divisor;
    logic  done;
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;

    division_result_t pending_divisions[$];
    division_result_t staged_result;
    int               mismatch_count = 0;
    int               quiet_cycles = 0;

    // Directed requests; known rows carry a result read straight off the rules
    division_vector_t directed_vectors[NUM_VECTORS] = '{
        {32'h0000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
        {32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
        {32'h1234_5678, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1},
        {32'h8000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1},
        {32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
        {32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 32'h0000_0000, 1'b0},
        {32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0},
        {32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000, 32'h0000_0000, 1'b0},
        {32'h8000_0001, 32'h0000_0001, 1'b1, 32'h8000_0001, 32'h0000_0000, 1'b0},
        {32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0001, 32'h0000_0000, 1'b0},
        {32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0},
        {32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0},
        {32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0},
        {32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
        {32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'h0000_0001, 1'b0},
        {32'h0000_0005, 32'h0000_0007, 1'b1, 32'h0000_0000, 32'h0000_0005, 1'b0},
        {32'h0000_0064, 32'h0000_000A, 1'b1, 32'h0000_000A, 32'h0000_0000, 1'b0},
        {32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'h0000_0002, 32'h0000_0000, 1'b0},
        {32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, 32'h5555_5555, 1'b0},
        {32'hDEAD_BEEF, 32'h0000_1234, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0},
        {32'h1234_5678, 32'h0000_9ABC, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0},
        {32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0}
    };

    unsigned_divide_with_remainder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .dividend       (dividend),
        .divisor        (divisor),
        .done           (done),
        .quotient       (quotient),
        .remainder      (remainder),
        .divide_by_zero (divide_by_zero)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Restoring division: try each quotient bit from the top, skip shifts that lose bits
    function automatic division_result_t restoring_divide(input word_t num, input word_t den);
        division_result_t res;
        word_t            partial;
        word_t            trial;
        res.quo = '0;
        res.rem = num;
        res.by_zero = 1'b0;
        if (den == '0)
        begin
            res.quo = '1;
            res.by_zero = 1'b1;
        end
        else
        begin
            partial = num;
            for (int pos = FIELD_WIDTH - 1; pos >= 0; pos--)
            begin
                trial = den << pos;
                if ((trial >> pos) == den && partial >= trial)
                begin
                    partial = partial - trial;
                    res.quo[pos] = 1'b1;
                end
            end
            res.rem = partial;
        end
        return res;
    endfunction

    // Print one line per mismatch, up to a cap, and count every one
    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s got %h, expected %h", $time, what, got, want);
    endtask

    // Operand with a random bit length, so quotients of every size turn up
    function automatic word_t shaped_operand();
        word_t value;
        value = $urandom;
        case ($urandom_range(7))
            0: value = '1;
            1: value = word_t'(1) << $urandom_range(FIELD_WIDTH - 1);
            default: value = value >> $urandom_range(FIELD_WIDTH - 1);
        endcase
        return value;
    endfunction

    // Drive one request from a falling edge and hold it until it is taken
    task automatic issue_division(input word_t num, input word_t den,
                                  input division_result_t want, input int idle_percent);
        bit paused;
        paused = 1'b0;
        while ($urandom_range(99) < idle_percent)
        begin
            if (!paused)
                start <= 1'b0;
            paused = 1'b1;
            dividend <= $urandom;
            divisor <= $urandom;
            @(negedge clk);
        end
        start <= 1'b1;
        dividend <= num;
        divisor <= den;
        staged_result <= want;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Take requests and check results at the rising edge
    always @(posedge clk)
    begin
        division_result_t expected;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (start && !busy)
                pending_divisions.push_back(staged_result);
            if (done)
            begin
                if (pending_divisions.size() == 0)
                    report_mismatch("result with no request waiting, quotient", quotient, '0);
                else
                begin
                    expected = pending_divisions.pop_front();
                    if (quotient !== expected.quo)
                        report_mismatch("quotient", quotient, expected.quo);
                    if (remainder !== expected.rem)
                        report_mismatch("remainder", remainder, expected.rem);
                    if (divide_by_zero !== expected.by_zero)
                        report_mismatch("divide_by_zero", word_t'(divide_by_zero),
                                        word_t'(expected.by_zero));
                end
            end
        end
    end

    // Abandon the run when nothing moves for too long
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int          idle_phases[4];
        word_t       num;
        word_t       den;
        division_vector_t vec;
        idle_phases = '{0, 72, 21, 0};
        rst_n = 1'b0;
        start = 1'b0;
        dividend = '0;
        divisor = '0;
        staged_result = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table back to back
        foreach (directed_vectors[i])
        begin
            vec = directed_vectors[i];
            issue_division(vec.num, vec.den,
                           vec.known ? vec.want : restoring_divide(vec.num, vec.den), 0);
        end

        // Random phases, draining the pipeline between each
        foreach (idle_phases[p])
        begin
            start <= 1'b0;
            while (pending_divisions.size() != 0)
                @(negedge clk);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                num = ($urandom_range(3) == 0) ? shaped_operand() : word_t'($urandom);
                case ($urandom_range(15))
                    0: den = '0;
                    1: den = word_t'(1);
                    2: den = word_t'($urandom);
                    default: den = shaped_operand();
                endcase
                issue_division(num, den, restoring_divide(num, den), idle_phases[p]);
            end
        end

        // Drain, then watch for stray results
        start <= 1'b0;
        while (pending_divisions.size() != 0)
            @(posedge clk);
        repeat (2 * DIV_LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
src/udivr_pkg.sv
src/udivr_stage.sv
src/unsigned_divide_with_remainder.sv
tb/sv/tb_top.sv
